FILE: sv/mi3_pkg.sv
// Shared widths, latencies and types of the 3x3 matrix inverse.
`default_nettype none
package mi3_pkg;

   localparam int ELEM_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int MAT_DIM   = 3;
   localparam int NUM_ELEMS = MAT_DIM * MAT_DIM;

   localparam int PROD_BITS = 2 * ELEM_BITS;
   localparam int COF_BITS  = 2 * ELEM_BITS + 1;
   localparam int PART_BITS = 2 * ELEM_BITS + 1;
   localparam int DET_BITS  = 3 * ELEM_BITS + 3;
   localparam int QUO_BITS  = ELEM_BITS + 1;
   localparam int NUM_BITS  = COF_BITS + 2 * FRAC_BITS;
   localparam int REM_BITS  = (NUM_BITS > DET_BITS + QUO_BITS) ? NUM_BITS
                                                               : DET_BITS + QUO_BITS;

   localparam int FRONT_LAT = 6;
   localparam int LANE_LAT  = QUO_BITS + 3;
   localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT;

   localparam int DATA_BITS = ((NUM_ELEMS * ELEM_BITS + 7) / 8) * 8;
   localparam int USER_BITS = 2;
   localparam int USER_SINGULAR = 0;
   localparam int USER_OVERFLOW = 1;

   typedef logic signed [ELEM_BITS-1:0] elem_type;
   typedef logic signed [COF_BITS-1:0]  cof_type;
   typedef logic signed [DET_BITS-1:0]  det_type;

   typedef struct packed {
      cof_type [NUM_ELEMS-1:0] adj;
      det_type                 det;
      logic                    det_zero;
   } front_out_type;

   typedef struct packed {
      elem_type value;
      logic     sat;
   } lane_out_type;

endpackage
`default_nettype wire

FILE: sv/matrix_inverse_3x3.sv
// Top level of the pipelined 3x3 fixed-point matrix inverse.
//
// Each input word on the req_ channel carries one 3x3 matrix of signed Q16.16
// elements in row-major order. Each output word on the rsp_ channel carries
// the inverse in the same layout, computed as adjugate over determinant with
// the determinant expanded along the first column. Every element is rounded
// to nearest with ties away from zero and saturated to the element range.
// rsp_tuser flags a singular matrix (all elements then zero) and saturation.
//
// The front end forms the nine cofactors and the determinant in six stages.
// Nine division lanes then work side by side, one per result element, each a
// restoring divider with one quotient bit per stage; the merge stage joins the
// lane results and the flags into the output register. From an accepted input
// word to rsp_tvalid a matrix passes six front stages, 36 lane stages set by
// the quotient width plus rounding, and the output register. Throughput is
// one matrix per cycle while the receiver does not stall.
//
// When the receiver stalls, one more word lands in a skid register and the
// whole pipeline then holds; req_tready comes straight from a flop. Reset is
// synchronous and empties the pipeline, the output and the skid register.
`default_nettype none
module matrix_inverse_3x3 (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // a00, a01, a02, a10, a11, a12, a20, a21, a22 from the lowest bit up
   input  wire logic [mi3_pkg::DATA_BITS-1:0]     req_tdata,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // r00, r01, r02, r10, r11, r12, r20, r21, r22 from the lowest bit up
   output      logic [mi3_pkg::DATA_BITS-1:0]     rsp_tdata,
   // singular, overflowed from the lowest bit up
   output      logic [mi3_pkg::USER_BITS-1:0]     rsp_tuser
);

   localparam int E  = mi3_pkg::ELEM_BITS;
   localparam int N  = mi3_pkg::NUM_ELEMS;
   localparam int PL = mi3_pkg::PIPE_LAT;
   localparam int LL = mi3_pkg::LANE_LAT;

   // The pipeline advances whenever the skid register is free.
   logic en;

   mi3_pkg::elem_type     a_in [N];
   mi3_pkg::front_out_type front_out;
   mi3_pkg::lane_out_type  lane_out [N];

   logic [PL-1:0] vld_ff;
   logic [LL-1:0] sing_ff;

   logic [mi3_pkg::DATA_BITS-1:0] merge_data;
   logic [mi3_pkg::USER_BITS-1:0] merge_user;
   logic                          any_sat;
   logic                          singular;

   logic                          rsp_vld_ff;
   logic [mi3_pkg::DATA_BITS-1:0] rsp_data_ff;
   logic [mi3_pkg::USER_BITS-1:0] rsp_user_ff;
   logic                          skid_vld_ff;
   logic [mi3_pkg::DATA_BITS-1:0] skid_data_ff;
   logic [mi3_pkg::USER_BITS-1:0] skid_user_ff;

   logic                          take;
   logic                          load_new;

   assign en         = !skid_vld_ff;
   assign req_tready = en;

   for (genvar k = 0; k < N; k++) begin : g_unpack
      assign a_in[k] = req_tdata[k*E +: E];
   end

   mi3_front u_front (
      .clock     (clock),
      .en        (en),
      .a_in      (a_in),
      .front_out (front_out)
   );

   for (genvar k = 0; k < N; k++) begin : g_lane
      mi3_lane u_lane (
         .clock    (clock),
         .en       (en),
         .cof      (front_out.adj[k]),
         .det      (front_out.det),
         .lane_out (lane_out[k])
      );
   end

   // Word-valid bits and the singular flag travel alongside the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PL-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff <= {sing_ff[LL-2:0], front_out.det_zero};
      end
   end

   // Merge: a singular matrix forces zero elements and clears the overflow flag.
   always_comb begin
      singular   = sing_ff[LL-1];
      any_sat    = 1'b0;
      merge_data = '0;
      for (int k = 0; k < N; k++) begin
         any_sat = any_sat | lane_out[k].sat;
         if (!singular) begin
            merge_data[k*E +: E] = lane_out[k].value;
         end
      end
      merge_user = '0;
      merge_user[mi3_pkg::USER_SINGULAR] = singular;
      merge_user[mi3_pkg::USER_OVERFLOW] = !singular && any_sat;
   end

   assign take     = rsp_vld_ff && rsp_tready;
   assign load_new = en && vld_ff[PL-1];

   // Output register plus skid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (take) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (load_new) begin
         if (!rsp_vld_ff || take) begin
            rsp_vld_ff <= 1'b1;
         end else begin
            skid_vld_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (take) begin
            rsp_data_ff <= skid_data_ff;
            rsp_user_ff <= skid_user_ff;
         end
      end else if (load_new) begin
         if (!rsp_vld_ff || take) begin
            rsp_data_ff <= merge_data;
            rsp_user_ff <= merge_user;
         end else begin
            skid_data_ff <= merge_data;
            skid_user_ff <= merge_user;
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // The skid register only holds a word while the output register is full.
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid register full while output register empty");

   // The skid register fills only after a stalled output word.
   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(rsp_vld_ff && !rsp_tready))
      else $error("skid register filled without a stall");

   // A singular result carries zero elements and no overflow flag.
   a_singular_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[mi3_pkg::USER_SINGULAR]) |->
         (!rsp_tuser[mi3_pkg::USER_OVERFLOW] && rsp_tdata == '0))
      else $error("singular result with nonzero elements or overflow");

endmodule
`default_nettype wire

FILE: sv/mi3_front.sv
// Cofactor and determinant pipeline feeding the division lanes.
`default_nettype none
module mi3_front (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire mi3_pkg::elem_type     a_in [mi3_pkg::NUM_ELEMS],
   output mi3_pkg::front_out_type     front_out
);

   localparam int E  = mi3_pkg::ELEM_BITS;
   localparam int N  = mi3_pkg::NUM_ELEMS;
   localparam int D  = mi3_pkg::MAT_DIM;
   localparam int PB = mi3_pkg::PROD_BITS;
   localparam int CB = mi3_pkg::COF_BITS;
   localparam int QB = mi3_pkg::PART_BITS;
   localparam int DB = mi3_pkg::DET_BITS;

   mi3_pkg::elem_type a_ff [N];
   logic signed [PB-1:0] prod_a_ff [N];
   logic signed [PB-1:0] prod_b_ff [N];
   logic signed [PB-1:0] prod_a_in [N];
   logic signed [PB-1:0] prod_b_in [N];
   mi3_pkg::elem_type col1_ff [D];
   mi3_pkg::elem_type col2_ff [D];
   mi3_pkg::cof_type  cof2_ff [N];
   mi3_pkg::cof_type  cof3_ff [N];
   mi3_pkg::cof_type  cof4_ff [N];
   mi3_pkg::cof_type  cof5_ff [N];
   logic signed [QB-1:0] phi_ff [D];
   logic signed [QB-1:0] plo_ff [D];
   mi3_pkg::det_type  row_ff [D];
   mi3_pkg::det_type  det_ff;

   // Cofactor (i,j) uses the cyclic minor, which carries its own sign.
   for (genvar i = 0; i < D; i++) begin : g_row
      for (genvar j = 0; j < D; j++) begin : g_col
         localparam int I1 = (i + 1) % D;
         localparam int I2 = (i + 2) % D;
         localparam int J1 = (j + 1) % D;
         localparam int J2 = (j + 2) % D;
         assign prod_a_in[i*D+j] = a_ff[I1*D+J1] * a_ff[I2*D+J2];
         assign prod_b_in[i*D+j] = a_ff[I1*D+J2] * a_ff[I2*D+J1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         for (int k = 0; k < N; k++) begin
            prod_a_ff[k] <= prod_a_in[k];
            prod_b_ff[k] <= prod_b_in[k];
            cof2_ff[k]   <= CB'(prod_a_ff[k]) - CB'(prod_b_ff[k]);
            cof3_ff[k]   <= cof2_ff[k];
            cof4_ff[k]   <= cof3_ff[k];
            cof5_ff[k]   <= cof4_ff[k];
         end
         for (int i = 0; i < D; i++) begin
            col1_ff[i] <= a_ff[i*D];
            col2_ff[i] <= col1_ff[i];
            // The wide cofactor is split so each multiplier stays near 32 bits.
            phi_ff[i]  <= col2_ff[i] * $signed(cof2_ff[i*D][CB-1:E]);
            plo_ff[i]  <= col2_ff[i] * $signed({1'b0, cof2_ff[i*D][E-1:0]});
            row_ff[i]  <= (DB'(phi_ff[i]) <<< E) + DB'(plo_ff[i]);
         end
         det_ff <= row_ff[0] + row_ff[1] + row_ff[2];
      end
   end

   // The adjugate is the transposed cofactor matrix.
   always_comb begin
      for (int i = 0; i < D; i++) begin
         for (int j = 0; j < D; j++) begin
            front_out.adj[i*D+j] = cof5_ff[j*D+i];
         end
      end
      front_out.det      = det_ff;
      front_out.det_zero = (det_ff == '0);
   end

endmodule
`default_nettype wire

FILE: sv/mi3_lane.sv
// One division lane: adjugate element over determinant, rounded and saturated.
`default_nettype none
module mi3_lane (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire mi3_pkg::cof_type    cof,
   input  wire mi3_pkg::det_type    det,
   output mi3_pkg::lane_out_type    lane_out
);

   localparam int E  = mi3_pkg::ELEM_BITS;
   localparam int F  = mi3_pkg::FRAC_BITS;
   localparam int CB = mi3_pkg::COF_BITS;
   localparam int DB = mi3_pkg::DET_BITS;
   localparam int QB = mi3_pkg::QUO_BITS;
   localparam int RB = mi3_pkg::REM_BITS;
   localparam logic [QB:0] HALF = (QB+1)'(1) << (E - 1);

   logic [CB-1:0] nmag;
   logic [DB-1:0] dmag;
   logic [RB-1:0] num0_ff;
   logic [DB-1:0] d0_ff;
   logic          rneg0_ff;

   logic [RB-1:0] rem_ff  [QB+1];
   logic [DB-1:0] d_ff    [QB+1];
   logic [QB-1:0] q_ff    [QB+1];
   logic          rneg_ff [QB+1];
   logic          big_ff  [QB+1];
   logic [RB:0]   trial   [QB];

   logic          rnd;
   logic [QB:0]   mag;
   logic [QB:0]   mag_neg;
   mi3_pkg::lane_out_type out_in;
   mi3_pkg::lane_out_type out_ff;

   assign nmag = cof[CB-1] ? CB'(-cof) : CB'(cof);
   assign dmag = det[DB-1] ? DB'(-det) : DB'(det);

   // Restoring division, one quotient bit per stage, most significant first.
   always_comb begin
      for (int s = 0; s < QB; s++) begin
         trial[s] = {1'b0, rem_ff[s]} - {1'b0, RB'(d_ff[s]) << (QB - 1 - s)};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num0_ff  <= RB'(nmag) << (2 * F);
         d0_ff    <= dmag;
         rneg0_ff <= cof[CB-1] ^ det[DB-1];

         // A quotient of 2^QB or more saturates whatever its low bits are.
         rem_ff[0]  <= num0_ff;
         d_ff[0]    <= d0_ff;
         q_ff[0]    <= '0;
         rneg_ff[0] <= rneg0_ff;
         big_ff[0]  <= (num0_ff >= (RB'(d0_ff) << QB));

         for (int s = 0; s < QB; s++) begin
            d_ff[s+1]    <= d_ff[s];
            rneg_ff[s+1] <= rneg_ff[s];
            big_ff[s+1]  <= big_ff[s];
            if (!trial[s][RB]) begin
               rem_ff[s+1] <= trial[s][RB-1:0];
               q_ff[s+1]   <= q_ff[s] | (QB'(1) << (QB - 1 - s));
            end else begin
               rem_ff[s+1] <= rem_ff[s];
               q_ff[s+1]   <= q_ff[s];
            end
         end

         out_ff <= out_in;
      end
   end

   // Round half away from zero on the magnitude, then clamp to the element range.
   always_comb begin
      rnd     = ({1'b0, rem_ff[QB][DB-1:0], 1'b0} >= {2'b00, d_ff[QB]});
      mag     = (QB+1)'(q_ff[QB]) + (QB+1)'(rnd);
      mag_neg = -mag;
      if (rneg_ff[QB]) begin
         if (big_ff[QB] || mag > HALF) begin
            out_in.value = {1'b1, {(E-1){1'b0}}};
            out_in.sat   = 1'b1;
         end else begin
            out_in.value = mag_neg[E-1:0];
            out_in.sat   = 1'b0;
         end
      end else begin
         if (big_ff[QB] || mag > HALF - 1'b1) begin
            out_in.value = {1'b0, {(E-1){1'b1}}};
            out_in.sat   = 1'b1;
         end else begin
            out_in.value = mag[E-1:0];
            out_in.sat   = 1'b0;
         end
      end
   end

   assign lane_out = out_ff;

endmodule
`default_nettype wire

FILE: bench/matrix_inverse_3x3_test.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_3x3_test;

   localparam int DATA_BITS     = mi3_pkg::DATA_BITS;
   localparam int USER_BITS     = mi3_pkg::USER_BITS;
   localparam int ELEM_BITS     = mi3_pkg::ELEM_BITS;
   localparam int FRAC_BITS     = mi3_pkg::FRAC_BITS;
   localparam int NUM_ELEMS     = mi3_pkg::NUM_ELEMS;
   localparam int PIPE_LAT      = mi3_pkg::PIPE_LAT;
   localparam int USER_SINGULAR = mi3_pkg::USER_SINGULAR;
   localparam int USER_OVERFLOW = mi3_pkg::USER_OVERFLOW;

   typedef mi3_pkg::elem_type elem_type;

   // Flag patterns on rsp_tuser.
   localparam logic [USER_BITS-1:0] FLAG_NONE     = '0;
   localparam logic [USER_BITS-1:0] FLAG_SINGULAR = USER_BITS'(1) << USER_SINGULAR;
   localparam logic [USER_BITS-1:0] FLAG_OVERFLOW = USER_BITS'(1) << USER_OVERFLOW;

   // Expected inverse of one matrix, packed as on the rsp_ channel.
   typedef struct {
      logic [DATA_BITS-1:0] data;
      logic [USER_BITS-1:0] user;
   } inverse_word_type;

   // One row of the directed stimulus. Rows with a known answer carry it;
   // the rest are checked against the predictor alone.
   typedef struct {
      logic [DATA_BITS-1:0] matrix;
      bit                   known;
      logic [DATA_BITS-1:0] known_data;
      logic [USER_BITS-1:0] known_user;
   } directed_row_type;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DIRECTED_ROWS = 14;
   localparam int RANDOM_ITEMS = 640;
   localparam elem_type ONE = elem_type'(1 << FRAC_BITS);
   localparam elem_type EMAX = elem_type'(32'h7fff_ffff);
   localparam elem_type EMIN = elem_type'(32'h8000_0000);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DATA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic [USER_BITS-1:0] rsp_tuser;

   int send_idle_pct = 16;
   int recv_idle_pct = 49;
   int mismatches = 0;
   int cycles = 0;
   inverse_word_type pending_inverses[$];
   directed_row_type directed_rows[DIRECTED_ROWS];

   matrix_inverse_3x3 i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Packs nine elements in row-major order, the first in the lowest bits.
   function automatic logic [DATA_BITS-1:0] pack_matrix(input elem_type e0, e1, e2, e3, e4,
                                                        e5, e6, e7, e8);
      logic [DATA_BITS-1:0] word;
      word = '0;
      word = {e8, e7, e6, e5, e4, e3, e2, e1, e0};
      return word;
   endfunction

   // Inverts by the adjugate over the determinant, the determinant expanded
   // along the first column. All intermediate values fit easily in 128 bits:
   // the determinant needs under 100 and the shifted cofactor under 97.
   function automatic inverse_word_type invert_matrix(input logic [DATA_BITS-1:0] word);
      logic signed [127:0] m[3][3];
      logic signed [127:0] cof[3][3];
      logic signed [127:0] det;
      logic [127:0] det_mag, num, quo, rem;
      logic num_neg, res_neg, saturated;
      inverse_word_type result;
      result.data = '0;
      result.user = '0;
      saturated = 1'b0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            m[i][j] = elem_type'(word[(i * 3 + j) * ELEM_BITS +: ELEM_BITS]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cof[i][j] = m[(i + 1) % 3][(j + 1) % 3] * m[(i + 2) % 3][(j + 2) % 3]
                      - m[(i + 1) % 3][(j + 2) % 3] * m[(i + 2) % 3][(j + 1) % 3];
         end
      end
      det = m[0][0] * cof[0][0] + m[1][0] * cof[1][0] + m[2][0] * cof[2][0];
      if (det == 0) begin
         result.user[USER_SINGULAR] = 1'b1;
         return result;
      end
      det_mag = (det < 0) ? -det : det;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            // The adjugate is the transposed cofactor matrix.
            num_neg = cof[j][i] < 0;
            num = (num_neg ? -cof[j][i] : cof[j][i]) << (2 * FRAC_BITS);
            quo = num / det_mag;
            rem = num % det_mag;
            // Round to nearest, ties away from zero, on the magnitude.
            if ((rem << 1) >= det_mag) quo = quo + 1;
            res_neg = num_neg != (det < 0);
            if (res_neg) begin
               if (quo > 128'h8000_0000) begin
                  quo = 128'h8000_0000;
                  saturated = 1'b1;
               end
               result.data[(i * 3 + j) * ELEM_BITS +: ELEM_BITS] = -quo[ELEM_BITS-1:0];
            end else begin
               if (quo > 128'h7fff_ffff) begin
                  quo = 128'h7fff_ffff;
                  saturated = 1'b1;
               end
               result.data[(i * 3 + j) * ELEM_BITS +: ELEM_BITS] = quo[ELEM_BITS-1:0];
            end
         end
      end
      result.user[USER_OVERFLOW] = saturated;
      return result;
   endfunction

   // A random element: mostly modest values near unity so that the inverse
   // stays in range, with full-range and extreme values mixed in.
   function automatic elem_type random_element();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return elem_type'($signed($urandom_range(32'h7ffff)) - 32'sh40000);
      if (pick < 80) return elem_type'($urandom);
      if (pick < 85) return EMAX;
      if (pick < 90) return EMIN;
      if (pick < 95) return elem_type'(0);
      return elem_type'($signed($urandom_range(15)) - 8);
   endfunction

   // A random matrix; some are made singular on purpose by repeating a row
   // or clearing a column, some keep only small off-diagonal elements, the rest are free.
   function automatic logic [DATA_BITS-1:0] random_matrix();
      elem_type e[9];
      int pick, src, dst;
      for (int k = 0; k < 9; k++) e[k] = random_element();
      pick = $urandom_range(99);
      if (pick < 10) begin
         src = $urandom_range(2);
         dst = (src + 1 + $urandom_range(1)) % 3;
         for (int j = 0; j < 3; j++) e[dst * 3 + j] = e[src * 3 + j];
      end else if (pick < 15) begin
         src = $urandom_range(2);
         for (int i = 0; i < 3; i++) e[i * 3 + src] = '0;
      end else if (pick < 25) begin
         for (int k = 0; k < 9; k++) begin
            if (k % 4 != 0) e[k] = elem_type'($signed($urandom_range(255)) - 128);
         end
      end
      return pack_matrix(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
   endfunction

   // Offers one word to the block and holds it until it is taken. Gaps are
   // inserted at the falling edge; acceptance is seen at the rising edge.
   task automatic offer_matrix(input logic [DATA_BITS-1:0] matrix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= matrix;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   // Accepted input words queue their expected inverse; accepted output words
   // are compared element by element with the oldest entry.
   always @(posedge clock) begin
      inverse_word_type expected;
      bit bad;
      if (!reset && req_tvalid && req_tready) begin
         pending_inverses.push_back(invert_matrix(req_tdata));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_inverses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected output word %h", rsp_tdata);
         end else begin
            expected = pending_inverses.pop_front();
            bad = rsp_tuser !== expected.user;
            for (int k = 0; k < NUM_ELEMS; k++) begin
               if (rsp_tdata[k * ELEM_BITS +: ELEM_BITS]
                   !== expected.data[k * ELEM_BITS +: ELEM_BITS]) bad = 1'b1;
            end
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("inverse mismatch: expected %h flags %b, got %h flags %b",
                           expected.data, expected.user, rsp_tdata, rsp_tuser);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int items_sent;
      elem_type z;
      inverse_word_type check;
      z = '0;
      // Identity inverts to itself.
      directed_rows[0] = '{pack_matrix(ONE, z, z, z, ONE, z, z, z, ONE), 1'b1,
                           pack_matrix(ONE, z, z, z, ONE, z, z, z, ONE), FLAG_NONE};
      // Zero matrix is singular with all elements zero.
      directed_rows[1] = '{'0, 1'b1, '0, FLAG_SINGULAR};
      // Smallest positive diagonal: the inverse saturates high.
      directed_rows[2] = '{pack_matrix(1, z, z, z, 1, z, z, z, 1), 1'b1,
                           pack_matrix(EMAX, z, z, z, EMAX, z, z, z, EMAX), FLAG_OVERFLOW};
      // Smallest negative diagonal: the inverse saturates low.
      directed_rows[3] = '{pack_matrix(-1, z, z, z, -1, z, z, z, -1), 1'b1,
                           pack_matrix(EMIN, z, z, z, EMIN, z, z, z, EMIN), FLAG_OVERFLOW};
      // All elements at the negative extreme: every row equal, so singular.
      directed_rows[4] = '{pack_matrix(EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN,
                                       EMIN), 1'b1, '0, FLAG_SINGULAR};
      // All elements at the positive extreme: also singular.
      directed_rows[5] = '{pack_matrix(EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX,
                                       EMAX), 1'b1, '0, FLAG_SINGULAR};
      // Extreme diagonal and extreme tridiagonal: tiny inverses, rounding near zero.
      directed_rows[6] = '{pack_matrix(EMAX, z, z, z, EMIN, z, z, z, EMAX), 1'b0, '0, '0};
      directed_rows[7] = '{pack_matrix(EMIN, EMAX, z, EMAX, EMIN, EMAX, z, EMAX, EMIN),
                           1'b0, '0, '0};
      // Diagonal of three: a quotient that is never exact.
      directed_rows[8] = '{pack_matrix(3 * ONE, z, z, z, -3 * ONE, z, z, z, 3 * ONE),
                           1'b0, '0, '0};
      // Diagonal of powers of two: every quotient is exact.
      directed_rows[9] = '{pack_matrix(elem_type'(32'h0002_0000) <<< 1, z, z, z,
                                       elem_type'(32'h0004_0000), z, z, z,
                                       elem_type'(32'h0000_8000)), 1'b0, '0, '0};
      // A dense well-conditioned matrix and a permutation.
      directed_rows[10] = '{pack_matrix(2 * ONE, ONE, z, ONE, 3 * ONE, ONE, z, ONE,
                                        4 * ONE), 1'b0, '0, '0};
      directed_rows[11] = '{pack_matrix(z, ONE, z, z, z, ONE, ONE, z, z), 1'b0, '0, '0};
      // First column zero: singular through the column expansion.
      directed_rows[12] = '{pack_matrix(z, ONE, 2 * ONE, z, 3 * ONE, ONE, z, ONE, ONE),
                            1'b1, '0, FLAG_SINGULAR};
      // Negative determinant from a reflected diagonal.
      directed_rows[13] = '{pack_matrix(-ONE, z, z, z, 2 * ONE, z, z, z, ONE),
                            1'b0, '0, '0};
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].known) begin
            check = invert_matrix(directed_rows[r].matrix);
            if (check.data !== directed_rows[r].known_data
                || check.user !== directed_rows[r].known_user) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("directed row %0d: expected %h flags %b, got %h flags %b", r,
                           directed_rows[r].known_data, directed_rows[r].known_user,
                           check.data, check.user);
               end
            end
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) offer_matrix(directed_rows[r].matrix);
      // Hold the sender until the pipeline has drained completely.
      req_tvalid <= 1'b0;
      while (pending_inverses.size() != 0) @(negedge clock);

      items_sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 49 : 0;
         recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 16 : 0;
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            offer_matrix(random_matrix());
            items_sent++;
         end
      end
      req_tvalid <= 1'b0;

      while (pending_inverses.size() != 0) @(negedge clock);
      // Let any stray extra word show up before the verdict.
      repeat (2 * PIPE_LAT) @(posedge clock);
      if (mismatches == 0 && pending_inverses.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
